// ----- rtl/core/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file of the block uses it.
package wsd_pkg;

    // Width of the frame length accumulator and payload counter (16..64).
    localparam int LEN_BITS = 64;

    // Frame header constants
    localparam logic [3:0] OPCODE_PING   = 4'h9;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [7:0] PONG_HDR0     = 8'h8A;
    localparam logic [7:0] PONG_LEN_EXT  = 8'd126;
    localparam int         PONG_LEN_MAX  = 125;

    // Result kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Result slot codes inside one descriptor
    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_LEN   = 2'd1;
    localparam logic [1:0] SLOT_LEN_H = 2'd2;
    localparam logic [1:0] SLOT_LEN_L = 2'd3;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HDR0 = 4'b0001,
        PH_HDR1 = 4'b0010,
        PH_EXT  = 4'b0100,
        PH_PAY  = 4'b1000
    } phase_t;

    // One classified input byte, as handed from the parser to the emitter
    typedef struct packed {
        logic [1:0]  rx_kind;
        logic [7:0]  rx_data;
        logic [3:0]  rx_opcode;
        logic        rx_frame_end;
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic        tx_frame_end;
        logic        pong;       // emit pong header (2 or 4 results)
        logic        pong_long;  // length over 125: 16-bit form
        logic        pong_empty; // zero-length ping
        logic [15:0] pong_len;   // low 16 bits of the length
    } desc_t;

endpackage

// ----- rtl/core/wsd_front.sv -----
// Header parser: takes one byte per transfer and classifies it into a descriptor.
// Depends on wsd_pkg.
module wsd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    output wsd_pkg::desc_t  out_desc
);

    wsd_pkg::phase_t               phase_reg, phase_next;
    logic [3:0]                    opcode_reg, opcode_next;
    logic                          ping_reg, ping_next;
    logic [3:0]                    ext_left_reg, ext_left_next;
    logic [wsd_pkg::LEN_BITS-1:0]  acc_reg, acc_next;
    logic [wsd_pkg::LEN_BITS-1:0]  left_reg, left_next;

    logic [wsd_pkg::LEN_BITS-1:0]  acc_shift;
    logic [wsd_pkg::LEN_BITS-1:0]  fin_len;
    logic [3:0]                    ext_dec;
    logic [6:0]                    len7;
    logic                          pay_last;
    logic                          do_finish;

    assign len7      = in_byte[6:0];
    assign acc_shift = {acc_reg[wsd_pkg::LEN_BITS-9:0], in_byte};
    assign ext_dec   = ext_left_reg - 4'd1;
    assign pay_last  = (left_reg[wsd_pkg::LEN_BITS-1:1] == '0);

    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        ping_next     = ping_reg;
        ext_left_next = ext_left_reg;
        acc_next      = acc_reg;
        left_next     = left_reg;
        out_desc      = '0;
        do_finish     = 1'b0;
        fin_len       = '0;

        case (phase_reg)
            wsd_pkg::PH_HDR0: begin
                opcode_next = in_byte[3:0];
                ping_next   = (in_byte[3:0] == wsd_pkg::OPCODE_PING);
                phase_next  = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1: begin
                acc_next = '0;
                if (len7 == wsd_pkg::LEN7_EXT16 || len7 == wsd_pkg::LEN7_EXT64) begin
                    ext_left_next = (len7 == wsd_pkg::LEN7_EXT64) ?
                                    wsd_pkg::EXT64_BYTES : wsd_pkg::EXT16_BYTES;
                    phase_next    = wsd_pkg::PH_EXT;
                end else begin
                    ext_left_next = '0;
                    acc_next      = {{(wsd_pkg::LEN_BITS-7){1'b0}}, len7};
                    do_finish     = 1'b1;
                    fin_len       = {{(wsd_pkg::LEN_BITS-7){1'b0}}, len7};
                end
            end
            wsd_pkg::PH_EXT: begin
                acc_next      = acc_shift;
                ext_left_next = ext_dec;
                if (ext_dec == 4'd0) begin
                    do_finish = 1'b1;
                    fin_len   = acc_shift;
                end
            end
            wsd_pkg::PH_PAY: begin
                out_desc.rx_kind      = wsd_pkg::KIND_BYTE;
                out_desc.rx_data      = in_byte;
                out_desc.rx_opcode    = opcode_reg;
                out_desc.rx_frame_end = pay_last;
                out_desc.tx_valid     = ping_reg;
                out_desc.tx_data      = ping_reg ? in_byte : 8'd0;
                out_desc.tx_frame_end = ping_reg & pay_last;
                left_next             = (left_reg == '0) ? left_reg : left_reg - 1'b1;
                if (pay_last) begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            end
            default: begin
                phase_next = wsd_pkg::PH_HDR0;
            end
        endcase

        // Header complete: load payload count, describe pong header / empty frame
        if (do_finish) begin
            left_next           = fin_len;
            phase_next          = (fin_len == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAY;
            out_desc.pong       = ping_reg;
            out_desc.pong_long  = (fin_len > wsd_pkg::LEN_BITS'(wsd_pkg::PONG_LEN_MAX));
            out_desc.pong_empty = (fin_len == '0);
            out_desc.pong_len   = fin_len[15:0];
            if (fin_len == '0) begin
                out_desc.rx_kind      = wsd_pkg::KIND_EMPTY;
                out_desc.rx_opcode    = opcode_reg;
                out_desc.rx_frame_end = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wsd_pkg::PH_HDR0;
            opcode_reg   <= '0;
            ping_reg     <= 1'b0;
            ext_left_reg <= '0;
            acc_reg      <= '0;
            left_reg     <= '0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            ping_reg     <= ping_next;
            ext_left_reg <= ext_left_next;
            acc_reg      <= acc_next;
            left_reg     <= left_next;
        end
    end

endmodule

// ----- rtl/core/wsd_queue.sv -----
// Four-entry descriptor queue between the parser and the result emitter.
// Depends on wsd_pkg.
module wsd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wsd_pkg::desc_t  push_desc,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output wsd_pkg::desc_t  head_desc
);

    wsd_pkg::desc_t  mem [4];
    logic [1:0]      wr_ptr_reg, wr_ptr_next;
    logic [1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]      count_reg, count_next;

    assign full      = (count_reg == 3'd4);
    assign not_empty = (count_reg != 3'd0);
    assign head_desc = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/wsd_back.sv -----
// Result emitter: expands one descriptor into one, two or four result transfers.
// Depends on wsd_pkg.
module wsd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            desc_valid,
    input  wsd_pkg::desc_t  desc,
    output logic            desc_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_rx_kind,
    output logic [7:0]      m_rx_data,
    output logic [3:0]      m_rx_opcode,
    output logic            m_rx_frame_end,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_data,
    output logic            m_tx_frame_end,
    output logic            m_run_last
);

    logic [1:0] slot_reg, slot_next;
    logic [1:0] last_slot;
    logic       fire;

    assign last_slot = desc.pong ? (desc.pong_long ? wsd_pkg::SLOT_LEN_L : wsd_pkg::SLOT_LEN) :
                       wsd_pkg::SLOT_FIRST;
    assign m_valid   = desc_valid;
    assign fire      = desc_valid & m_ready;
    assign m_run_last = (slot_reg == last_slot);
    assign desc_pop  = fire & m_run_last;

    always_comb begin
        m_rx_kind      = wsd_pkg::KIND_NONE;
        m_rx_data      = '0;
        m_rx_opcode    = '0;
        m_rx_frame_end = 1'b0;
        m_tx_valid     = 1'b1;
        m_tx_data      = '0;
        m_tx_frame_end = 1'b0;
        case (slot_reg)
            wsd_pkg::SLOT_FIRST: begin
                m_rx_kind      = desc.rx_kind;
                m_rx_data      = desc.rx_data;
                m_rx_opcode    = desc.rx_opcode;
                m_rx_frame_end = desc.rx_frame_end;
                m_tx_valid     = desc.pong | desc.tx_valid;
                m_tx_data      = desc.pong ? wsd_pkg::PONG_HDR0 : desc.tx_data;
                m_tx_frame_end = desc.pong ? 1'b0 : desc.tx_frame_end;
            end
            wsd_pkg::SLOT_LEN: begin
                m_tx_data      = desc.pong_long ? wsd_pkg::PONG_LEN_EXT :
                                 {1'b0, desc.pong_len[6:0]};
                m_tx_frame_end = desc.pong_empty & ~desc.pong_long;
            end
            wsd_pkg::SLOT_LEN_H: begin
                m_tx_data = desc.pong_len[15:8];
            end
            wsd_pkg::SLOT_LEN_L: begin
                m_tx_data      = desc.pong_len[7:0];
                m_tx_frame_end = desc.pong_empty;
            end
            default: begin
                m_tx_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        slot_next = slot_reg;
        if (fire) begin
            slot_next = m_run_last ? wsd_pkg::SLOT_FIRST : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= wsd_pkg::SLOT_FIRST;
        end else begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ----- rtl/core/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket frame deframer with automatic pong reply.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_valid / s_ready    s_rx_byte
//   m_*       out        m_valid / m_ready    m_rx_*, m_tx_*, m_run_last
//
// Cycles: the parser takes one byte per cycle while s_ready is high; each byte
//   becomes one result, except the byte that completes a ping header, which
//   becomes two results (short length) or four (16-bit length form).
// The emitter sends one result per cycle while m_ready is high, so the sustained rate
//   is one byte per cycle, set by the single-result output port, less during pong headers.
// A four-entry descriptor queue lets the parser run ahead of a stalled output.
// s_ready drops only when the queue is full.
// Reset (synchronous, active low) returns the parser to the first header byte
//   and empties the queue.
module websocket_frame_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_rx_kind,
    output logic [7:0]  m_rx_data,
    output logic [3:0]  m_rx_opcode,
    output logic        m_rx_frame_end,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_data,
    output logic        m_tx_frame_end,
    output logic        m_run_last
);

    wsd_pkg::desc_t front_desc;
    wsd_pkg::desc_t head_desc;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           in_fire;

    // Accept whenever the queue has room; parser state advances on transfer
    assign s_ready = ~q_full;
    assign in_fire = s_valid & ~q_full;

    wsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_rx_byte),
        .out_desc (front_desc)
    );

    // Hold classified bytes until the emitter drains them
    wsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_desc (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    // Expand each descriptor into its result transfers
    wsd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .desc_valid     (q_not_empty),
        .desc           (head_desc),
        .desc_pop       (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rx_kind      (m_rx_kind),
        .m_rx_data      (m_rx_data),
        .m_rx_opcode    (m_rx_opcode),
        .m_rx_frame_end (m_rx_frame_end),
        .m_tx_valid     (m_tx_valid),
        .m_tx_data      (m_tx_data),
        .m_tx_frame_end (m_tx_frame_end),
        .m_run_last     (m_run_last)
    );

endmodule

// ----- rtl/core/wsd_checker.sv -----
// Port-level checks for the deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer_core.
module wsd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_rx_kind,
    input  logic [7:0]  m_rx_data,
    input  logic [3:0]  m_rx_opcode,
    input  logic        m_rx_frame_end,
    input  logic        m_tx_valid,
    input  logic [7:0]  m_tx_data,
    input  logic        m_tx_frame_end
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rx_kind == wsd_pkg::KIND_NONE || m_rx_kind == wsd_pkg::KIND_BYTE ||
                     m_rx_kind == wsd_pkg::KIND_EMPTY))
        else $error("bad rx kind");

    a_rx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_kind == wsd_pkg::KIND_NONE |->
            m_rx_data == 8'd0 && m_rx_opcode == 4'd0 && !m_rx_frame_end)
        else $error("rx fields set without delivery");

    a_tx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_data == 8'd0 && !m_tx_frame_end)
        else $error("tx fields set without pong byte");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_rx_kind      (m_rx_kind),
    .m_rx_data      (m_rx_data),
    .m_rx_opcode    (m_rx_opcode),
    .m_rx_frame_end (m_rx_frame_end),
    .m_tx_valid     (m_tx_valid),
    .m_tx_data      (m_tx_data),
    .m_tx_frame_end (m_tx_frame_end)
);
